### rtl/pcbm_pkg.sv
package pcbm_pkg;

    localparam int unsigned ChanW = 8;
    localparam int unsigned ModeW = 3;
    localparam int unsigned IdxW  = 2;

    localparam logic [ModeW-1:0] MODE_ADD_CLAMP = 3'd0;
    localparam logic [ModeW-1:0] MODE_ADD_WRAP  = 3'd1;
    localparam logic [ModeW-1:0] MODE_SUB_CLAMP = 3'd2;
    localparam logic [ModeW-1:0] MODE_SUB_WRAP  = 3'd3;
    localparam logic [ModeW-1:0] MODE_MUL       = 3'd4;
    localparam logic [ModeW-1:0] MODE_MUL2      = 3'd5;
    localparam logic [ModeW-1:0] MODE_BLEND     = 3'd6;
    localparam logic [ModeW-1:0] MODE_ALPHA     = 3'd7;

    localparam logic [IdxW-1:0] REG_BLEND_MODE    = 2'd0;
    localparam logic [IdxW-1:0] REG_PERCENT_RED   = 2'd1;
    localparam logic [IdxW-1:0] REG_PERCENT_GREEN = 2'd2;
    localparam logic [IdxW-1:0] REG_PERCENT_BLUE  = 2'd3;

    localparam logic [ModeW-1:0] MODE_RESET = MODE_ADD_CLAMP;
    localparam logic [ChanW-1:0] PCT_RESET  = 8'd255;
    localparam logic [ChanW-1:0] CHAN_MAX   = 8'd255;

    typedef struct packed {
        logic [ChanW-1:0] dst_red;
        logic [ChanW-1:0] dst_green;
        logic [ChanW-1:0] dst_blue;
        logic [ChanW-1:0] dst_alpha;
        logic [ChanW-1:0] src_red;
        logic [ChanW-1:0] src_green;
        logic [ChanW-1:0] src_blue;
        logic [ChanW-1:0] src_alpha;
    } pix_t;

    typedef struct packed {
        logic [ChanW-1:0] out_red;
        logic [ChanW-1:0] out_green;
        logic [ChanW-1:0] out_blue;
        logic [ChanW-1:0] out_alpha;
    } res_t;

    typedef struct packed {
        logic [ModeW-1:0] blend_mode;
        logic [ChanW-1:0] percent_red;
        logic [ChanW-1:0] percent_green;
        logic [ChanW-1:0] percent_blue;
    } cfg_t;

endpackage

### rtl/pcbm_cfg.sv
module pcbm_cfg
    import pcbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IdxW-1:0]  cfg_index,
    input  logic [ChanW-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLEND_MODE:    cfg_next.blend_mode    = cfg_data[ModeW-1:0];
                REG_PERCENT_RED:   cfg_next.percent_red   = cfg_data;
                REG_PERCENT_GREEN: cfg_next.percent_green = cfg_data;
                REG_PERCENT_BLUE:  cfg_next.percent_blue  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_mode    <= MODE_RESET;
            cfg_reg.percent_red   <= PCT_RESET;
            cfg_reg.percent_green <= PCT_RESET;
            cfg_reg.percent_blue  <= PCT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/pcbm_pipe.sv
module pcbm_pipe
    import pcbm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic pix_valid,
    output logic pix_ready,
    input  pix_t pix,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    // channel order: 0 red, 1 green, 2 blue, 3 alpha
    typedef struct packed {
        logic [ModeW-1:0]          mode;
        logic [3:0][ChanW-1:0]     d;
        logic [3:0][ChanW-1:0]     s;
    } st1_t;

    typedef struct packed {
        logic [ModeW-1:0]          mode;
        logic [3:0][ChanW-1:0]     d;
        logic [3:0][ChanW:0]       sum;
        logic [2:0][ChanW:0]       diff;
        logic [2:0][2*ChanW-1:0]   prod;
    } st2_t;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    st1_t s1_reg;
    st1_t s1_next;
    st2_t s2_reg;
    st2_t s2_next;
    res_t s3_reg;
    res_t s3_next;

    logic en1;
    logic en2;
    logic en3;

    function automatic logic [ChanW-1:0] scale(input logic [ChanW-1:0] v,
                                               input logic [ChanW-1:0] pct);
        logic [2*ChanW-1:0] p;
        p = {{ChanW{1'b0}}, v} * {{ChanW{1'b0}}, pct};
        return p[2*ChanW-1:ChanW];
    endfunction

    function automatic logic [ChanW-1:0] pick(input logic [ModeW-1:0]   mode,
                                              input logic [ChanW-1:0]   d,
                                              input logic [ChanW:0]     sum,
                                              input logic [ChanW:0]     diff,
                                              input logic [2*ChanW-1:0] prod);
        logic [ChanW-1:0] r;
        r = d;
        unique case (mode)
            MODE_ADD_CLAMP: r = (sum >= {1'b0, CHAN_MAX}) ? CHAN_MAX : sum[ChanW-1:0];
            MODE_ADD_WRAP:  r = (sum >= {1'b0, CHAN_MAX}) ?
                                ChanW'(sum - {1'b0, CHAN_MAX}) : sum[ChanW-1:0];
            MODE_SUB_CLAMP: r = diff[ChanW] ? '0 : diff[ChanW-1:0];
            MODE_SUB_WRAP:  r = (diff[ChanW-1:0] == CHAN_MAX) ? '0 : diff[ChanW-1:0];
            MODE_MUL:       r = prod[2*ChanW-1:ChanW];
            MODE_MUL2:      r = prod[2*ChanW-1] ? CHAN_MAX : prod[2*ChanW-2:ChanW-1];
            MODE_BLEND:     r = sum[ChanW:1];
            MODE_ALPHA:     r = d;
            default:        r = d;
        endcase
        return r;
    endfunction

    assign en3       = !s3_valid_reg || res_ready;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign pix_ready = en1;

    // stage 1: scale the source by its percent (alpha by the blue percent)
    always_comb
    begin
        s1_next.mode = cfg.blend_mode;
        s1_next.d[0] = pix.dst_red;
        s1_next.d[1] = pix.dst_green;
        s1_next.d[2] = pix.dst_blue;
        s1_next.d[3] = pix.dst_alpha;
        s1_next.s[0] = scale(pix.src_red, cfg.percent_red);
        s1_next.s[1] = scale(pix.src_green, cfg.percent_green);
        s1_next.s[2] = scale(pix.src_blue, cfg.percent_blue);
        s1_next.s[3] = scale(pix.src_alpha, cfg.percent_blue);
    end

    // stage 2: sums, differences and products
    always_comb
    begin
        s2_next.mode = s1_reg.mode;
        s2_next.d    = s1_reg.d;
        for (int i = 0; i < 4; i++)
        begin
            s2_next.sum[i] = {1'b0, s1_reg.d[i]} + {1'b0, s1_reg.s[i]};
        end
        for (int i = 0; i < 3; i++)
        begin
            s2_next.diff[i] = {1'b0, s1_reg.d[i]} - {1'b0, s1_reg.s[i]};
            s2_next.prod[i] = {{ChanW{1'b0}}, s1_reg.d[i]} * {{ChanW{1'b0}}, s1_reg.s[i]};
        end
    end

    // stage 3: mode select and clamp
    always_comb
    begin
        s3_next.out_red   = pick(s2_reg.mode, s2_reg.d[0], s2_reg.sum[0],
                                 s2_reg.diff[0], s2_reg.prod[0]);
        s3_next.out_green = pick(s2_reg.mode, s2_reg.d[1], s2_reg.sum[1],
                                 s2_reg.diff[1], s2_reg.prod[1]);
        s3_next.out_blue  = pick(s2_reg.mode, s2_reg.d[2], s2_reg.sum[2],
                                 s2_reg.diff[2], s2_reg.prod[2]);
        s3_next.out_alpha = (s2_reg.mode == MODE_ALPHA) ? s2_reg.sum[3][ChanW:1]
                                                        : s2_reg.d[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= pix_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && pix_valid)
        begin
            s1_reg <= s1_next;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (en3 && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign res_valid = s3_valid_reg;
    assign res       = s3_reg;

    a_entry_lands: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready |=> s1_valid_reg)
        else $error("accepted transfer missing from stage 1");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !en2 |=> s1_valid_reg && $stable(s1_reg))
        else $error("stalled stage 1 item changed");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !en3 |=> s2_valid_reg && $stable(s2_reg))
        else $error("stalled stage 2 item changed");

    a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && en3 |=> res_valid)
        else $error("stage 2 item lost on the way to the output");

endmodule

### rtl/pixel_combine_blend_modes.sv
// pixel combine with blend modes
// pix channel: one destination and one source pixel per transfer, valid/ready
// res channel: one combined pixel per accepted pix transfer, valid/ready, in order
// cfg port: write enable, 2-bit index and 8-bit data, taken on any clock edge
//   index 0 blend mode, 1 red percent, 2 green percent, 3 blue percent
//   write only while no pixel is in flight
// throughput: one pixel per cycle when res_ready stays high
// pipeline: an accepted pixel passes three registered stages, res_valid is the stage 3 valid
//   stage 1 percent scaling, stage 2 sum/difference/8x8 product,
//   stage 3 mode select and clamp into the output register
// stall: res_ready low holds the output, stages fill behind it and
//   pix_ready drops only once all three stages hold an item
// reset: pipeline empties, blend mode returns to add clamp and every
//   percent to 255
module pixel_combine_blend_modes
    import pcbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IdxW-1:0]  cfg_index,
    input  logic [ChanW-1:0] cfg_data,
    input  logic             pix_valid,
    output logic             pix_ready,
    input  pix_t             pix,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res
);

    cfg_t cfg;

    pcbm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcbm_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

### tb/sv/blend_checker.sv
module blend_checker
    import pcbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IdxW-1:0]  cfg_index,
    input  logic [ChanW-1:0] cfg_data,
    input  logic             pix_valid,
    input  logic             pix_ready,
    input  pix_t             pix,
    input  logic             res_valid,
    input  logic             res_ready,
    input  res_t             res,
    output int               errors,
    output int               pending
);

    logic [ModeW-1:0] mode_q;
    logic [ChanW-1:0] pct_red_q;
    logic [ChanW-1:0] pct_green_q;
    logic [ChanW-1:0] pct_blue_q;
    res_t             expected_pixels[$];

    initial errors = 0;
    initial pending = 0;

    function automatic logic [ChanW-1:0] scale_chan(
        input logic [ChanW-1:0] v,
        input logic [ChanW-1:0] pct
    );
        logic [2*ChanW-1:0] prod;
        prod = v * pct;
        return prod[2*ChanW-1:ChanW];
    endfunction

    function automatic logic [ChanW-1:0] combine_chan(
        input logic [ModeW-1:0] mode,
        input logic [ChanW-1:0] d,
        input logic [ChanW-1:0] s
    );
        logic [ChanW+1:0]   sum;
        logic [2*ChanW-1:0] prod;
        sum  = d + s;
        prod = d * s;
        case (mode)
            MODE_ADD_CLAMP: return (sum > CHAN_MAX) ? CHAN_MAX : sum[ChanW-1:0];
            MODE_ADD_WRAP:  return ChanW'(sum % CHAN_MAX);
            MODE_SUB_CLAMP: return (d > s) ? d - s : '0;
            MODE_SUB_WRAP:
            begin
                if (d >= s)
                    return ChanW'((d - s) % CHAN_MAX);
                // borrow case of the 8-bit wrapping subtraction
                return ChanW'((10'd256 + d - s) % CHAN_MAX);
            end
            MODE_MUL:       return prod[2*ChanW-1:ChanW];
            MODE_MUL2:
            begin
                if (prod[2*ChanW-1:ChanW-1] > CHAN_MAX)
                    return CHAN_MAX;
                return prod[2*ChanW-2:ChanW-1];
            end
            MODE_BLEND:     return sum[ChanW:1];
            default:        return d;
        endcase
    endfunction

    function automatic res_t blend_pixel(input pix_t p);
        res_t           r;
        logic [ChanW:0] alpha_sum;
        if (mode_q == MODE_ALPHA)
        begin
            alpha_sum   = p.dst_alpha + scale_chan(p.src_alpha, pct_blue_q);
            r.out_red   = p.dst_red;
            r.out_green = p.dst_green;
            r.out_blue  = p.dst_blue;
            r.out_alpha = alpha_sum[ChanW:1];
        end
        else
        begin
            r.out_red   = combine_chan(mode_q, p.dst_red, scale_chan(p.src_red, pct_red_q));
            r.out_green = combine_chan(mode_q, p.dst_green,
                                       scale_chan(p.src_green, pct_green_q));
            r.out_blue  = combine_chan(mode_q, p.dst_blue, scale_chan(p.src_blue, pct_blue_q));
            r.out_alpha = p.dst_alpha;
        end
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] %s", $time, msg);
        errors++;
    endtask

    task automatic check_pixel(input res_t got, input res_t want);
        if (got.out_red !== want.out_red)
            report_error($sformatf("out_red got %0d expected %0d", got.out_red, want.out_red));
        if (got.out_green !== want.out_green)
            report_error($sformatf("out_green got %0d expected %0d",
                                   got.out_green, want.out_green));
        if (got.out_blue !== want.out_blue)
            report_error($sformatf("out_blue got %0d expected %0d", got.out_blue, want.out_blue));
        if (got.out_alpha !== want.out_alpha)
            report_error($sformatf("out_alpha got %0d expected %0d",
                                   got.out_alpha, want.out_alpha));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            mode_q      <= MODE_RESET;
            pct_red_q   <= PCT_RESET;
            pct_green_q <= PCT_RESET;
            pct_blue_q  <= PCT_RESET;
            expected_pixels.delete();
        end
        else
        begin
            if (pix_valid && pix_ready)
                expected_pixels.push_back(blend_pixel(pix));
            if (res_valid && res_ready)
            begin
                if (expected_pixels.size() == 0)
                    report_error("result transfer with no pixel pending");
                else
                begin
                    want = expected_pixels.pop_front();
                    check_pixel(res, want);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BLEND_MODE:    mode_q      <= cfg_data[ModeW-1:0];
                    REG_PERCENT_RED:   pct_red_q   <= cfg_data;
                    REG_PERCENT_GREEN: pct_green_q <= cfg_data;
                    REG_PERCENT_BLUE:  pct_blue_q  <= cfg_data;
                    default:           ;
                endcase
            end
        end
        pending = expected_pixels.size();
    end

endmodule

### tb/sv/tb_top.sv
module tb_top
    import pcbm_pkg::*;
();

    localparam int SettleCycles = 4;
    localparam int CycleLimit   = 200000;
    localparam int Segments     = 24;
    localparam int SegmentItems = 42;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [IdxW-1:0]  cfg_index = '0;
    logic [ChanW-1:0] cfg_data  = '0;
    logic             pix_valid = 1'b0;
    logic             pix_ready;
    pix_t             pix       = '0;
    logic             res_valid;
    logic             res_ready = 1'b0;
    res_t             res;
    int               errors;
    int               pending;
    int               cycles    = 0;
    int               send_idle = 16;
    int               recv_idle = 48;
    pix_t             pix_queue[$];

    pixel_combine_blend_modes dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    blend_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("pixel_combine_blend_modes: mismatch");
            $finish;
        end
    end

    // pixel sender: the queue head stays put until its transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
                void'(pix_queue.pop_front());
            if (!pix_valid || pix_ready)
            begin
                if (pix_queue.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    pix_valid <= 1'b1;
                    pix       <= pix_queue[0];
                end
                else
                    pix_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        res_ready <= ($urandom_range(99) >= recv_idle);

    function automatic logic [ChanW-1:0] rand_chan();
        case ($urandom_range(7))
            0:       return '0;
            1:       return CHAN_MAX;
            default: return ChanW'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [ChanW-1:0] rand_pct();
        case ($urandom_range(5))
            0:       return '0;
            1:       return CHAN_MAX;
            2:       return 8'd1;
            default: return ChanW'($urandom_range(255));
        endcase
    endfunction

    function automatic pix_t rand_pixel();
        pix_t p;
        p = {rand_chan(), rand_chan(), rand_chan(), rand_chan(),
             rand_chan(), rand_chan(), rand_chan(), rand_chan()};
        return p;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pix_queue.size() != 0 || pix_valid || pending != 0);
    endtask

    task automatic write_settings(
        input logic [ModeW-1:0] mode,
        input logic [ChanW-1:0] pct_red,
        input logic [ChanW-1:0] pct_green,
        input logic [ChanW-1:0] pct_blue
    );
        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BLEND_MODE;
        cfg_data  <= ChanW'(mode);
        @(posedge clk);
        cfg_index <= REG_PERCENT_RED;
        cfg_data  <= pct_red;
        @(posedge clk);
        cfg_index <= REG_PERCENT_GREEN;
        cfg_data  <= pct_green;
        @(posedge clk);
        cfg_index <= REG_PERCENT_BLUE;
        cfg_data  <= pct_blue;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        pix_t mixed;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // destination below and above the source, and equal to zero, against assorted sources
        mixed = {8'h10, 8'hff, 8'h00, 8'h5a, 8'hff, 8'h10, 8'h80, 8'hc3};
        for (int m = MODE_ADD_CLAMP; m <= MODE_ALPHA; m++)
        begin
            write_settings(ModeW'(m), CHAN_MAX, m[0] ? 8'd0 : 8'd128,
                           m[1] ? 8'd1 : CHAN_MAX);
            pix_queue.push_back('0);
            pix_queue.push_back('1);
            pix_queue.push_back(mixed);
        end

        for (int seg = 0; seg < Segments; seg++)
        begin
            if (seg == Segments / 3)
            begin
                send_idle = 48;
                recv_idle = 16;
            end
            if (seg == 2 * Segments / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_settings(ModeW'(seg), rand_pct(), rand_pct(), rand_pct());
            for (int i = 0; i < SegmentItems; i++)
                pix_queue.push_back(rand_pixel());
        end

        wait_drained();
        repeat (2 * SettleCycles) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("pixel_combine_blend_modes: match");
        else
            $display("pixel_combine_blend_modes: mismatch");
        $finish;
    end

endmodule
